// ----- sv/eas_pkg.sv -----
// Shared types, constants and codes of the EAROM access sequencer.
package eas_pkg;

    // Storage geometry
    localparam int EAROM_BYTES = 64;
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int RWAIT_W     = 10;
    localparam int CWAIT_W     = 20;
    localparam int OFFSET_W    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Sequencer step counter
    localparam int STEP_W      = 3;

    // Input opcodes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_RETURN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SWAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_WAIT = 3'd5;

    // Control latch bits: D0 clock, D1/D2 mode pins, D3 chip select
    localparam logic [BYTE_W-1:0] CTL_REST = 8'h00;
    localparam logic [BYTE_W-1:0] CTL_WIPE = 8'h06;
    localparam logic [BYTE_W-1:0] CTL_WR_A = 8'h02;
    localparam logic [BYTE_W-1:0] CTL_WR_B = 8'h04;
    localparam logic [BYTE_W-1:0] CTL_CLK  = 8'h01;
    localparam logic [BYTE_W-1:0] CTL_CS   = 8'h08;

    // Reset values of configuration
    localparam logic [RWAIT_W-1:0] READ_WAIT_RST  = 10'd2;
    localparam logic [CWAIT_W-1:0] CYCLE_WAIT_RST = 20'd50000;

    // Last step index of each command
    localparam logic [STEP_W-1:0] STEP_LAST_REQ = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST_RET = 3'd1;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_RETURN = 2'd2
    } eas_cmd_t;

    typedef enum logic [1:0] {
        KIND_BUS_WRITE = 2'd0,
        KIND_BUS_READ  = 2'd1,
        KIND_WAIT      = 2'd2,
        KIND_DONE      = 2'd3
    } eas_kind_t;

    // Classified command queued for the back end
    typedef struct packed {
        eas_cmd_t            cmd;
        logic [ADDR_W-1:0]   addr;   // latch address for requests
        logic [BYTE_W-1:0]   data;   // write byte or returned byte
        logic                err;    // bus read error on return
    } eas_entry_t;

    // Configuration register set
    typedef struct packed {
        logic [ADDR_W-1:0]   write_base;
        logic [ADDR_W-1:0]   control_addr;
        logic [ADDR_W-1:0]   read_addr;
        logic                mode_swapped;
        logic [RWAIT_W-1:0]  read_wait;
        logic [CWAIT_W-1:0]  cycle_wait;
    } eas_cfg_t;

    // One result beat
    typedef struct packed {
        eas_kind_t           kind;
        logic [ADDR_W-1:0]   bus_address;
        logic [BYTE_W-1:0]   bus_data;
        logic [CWAIT_W-1:0]  wait_us;
        logic [BYTE_W-1:0]   read_value;
        logic                read_error;
        logic                last;
    } eas_beat_t;

endpackage

// ----- sv/earom_access_sequencer.sv -----
// Top level of the EAROM access sequencer: configuration registers and wiring.
//
//  channel | dir | handshake                | payload
//  s_      | in  | s_tvalid / s_tready      | s_tuser opcode, s_tdata request fields
//  m_      | out | m_tvalid / m_tready      | m_tuser kind, m_tdata result, m_tlast
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A request gives seven result beats, a read return two, one beat per cycle
// from the back end sequencer while the result side takes them, each beat
// registered at the output. The four-entry command queue keeps taking input
// until full while the sequencer works or the result side stalls. Synchronous
// active-low reset clears the pending read, the queue and the sequencer and
// loads the configuration defaults. Configuration writes are always taken.
module earom_access_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // offset[5:0], write_data[13:6],
                                   // bus_read_value[29:14], bus_read_error[30]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bus_address[15:0], bus_data[23:16],
                                   // wait_us[43:24], read_value[51:44],
                                   // read_error[52]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [eas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eas_pkg::CFG_DATA_W-1:0] cfg_data
);

    eas_pkg::eas_cfg_t   cfg_reg;
    eas_pkg::eas_cfg_t   cfg_next;
    eas_pkg::eas_entry_t push_entry;
    eas_pkg::eas_entry_t head;
    eas_pkg::eas_beat_t  beat;
    logic                q_push;
    logic                q_pop;
    logic                q_not_full;
    logic                q_not_empty;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                eas_pkg::REG_WRITE_BASE:
                    cfg_next.write_base   = cfg_data[eas_pkg::ADDR_W-1:0];
                eas_pkg::REG_CONTROL:
                    cfg_next.control_addr = cfg_data[eas_pkg::ADDR_W-1:0];
                eas_pkg::REG_READ_ADDR:
                    cfg_next.read_addr    = cfg_data[eas_pkg::ADDR_W-1:0];
                eas_pkg::REG_MODE_SWAP:
                    cfg_next.mode_swapped = cfg_data[0];
                eas_pkg::REG_READ_WAIT:
                    cfg_next.read_wait    = cfg_data[eas_pkg::RWAIT_W-1:0];
                eas_pkg::REG_CYCLE_WAIT:
                    cfg_next.cycle_wait   = cfg_data[eas_pkg::CWAIT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.write_base   <= '0;
            cfg_reg.control_addr <= '0;
            cfg_reg.read_addr    <= '0;
            cfg_reg.mode_swapped <= 1'b0;
            cfg_reg.read_wait    <= eas_pkg::READ_WAIT_RST;
            cfg_reg.cycle_wait   <= eas_pkg::CYCLE_WAIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    eas_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .opcode         (s_tuser),
        .offset         (s_tdata[5:0]),
        .write_data     (s_tdata[13:6]),
        .bus_read_value (s_tdata[29:14]),
        .bus_read_error (s_tdata[30]),
        .cfg            (cfg_reg),
        .q_ready        (q_not_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    eas_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    eas_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_head  (head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_beat  (beat)
    );

    // pack the result beat
    assign m_tdata = {3'b000, beat.read_error, beat.read_value, beat.wait_us,
                      beat.bus_data, beat.bus_address};
    assign m_tuser = beat.kind;
    assign m_tlast = beat.last;

endmodule

// ----- sv/eas_front.sv -----
// Front end: accepts input beats, tracks the pending read and queues commands.
module eas_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [1:0]               opcode,
    input  logic [eas_pkg::OFFSET_W-1:0] offset,
    input  logic [eas_pkg::BYTE_W-1:0]   write_data,
    input  logic [eas_pkg::ADDR_W-1:0]   bus_read_value,
    input  logic                     bus_read_error,
    input  eas_pkg::eas_cfg_t        cfg,
    input  logic                     q_ready,
    output logic                     q_push,
    output eas_pkg::eas_entry_t      q_entry
);

    logic pending_reg;
    logic pending_next;
    logic accept;
    logic [eas_pkg::ADDR_W-1:0] latch_addr;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;

    // offset wraps at the size of the part, then adds with 16-bit wrap
    assign latch_addr = cfg.write_base
                      + eas_pkg::ADDR_W'(offset % eas_pkg::EAROM_BYTES);

    // classify the beat
    always_comb begin
        pending_next  = pending_reg;
        q_push        = 1'b0;
        q_entry.cmd   = eas_pkg::CMD_READ;
        q_entry.addr  = latch_addr;
        q_entry.data  = '0;
        q_entry.err   = 1'b0;
        if (accept) begin
            case (opcode)
                eas_pkg::OP_READ: begin
                    if (!pending_reg) begin
                        q_push       = 1'b1;
                        pending_next = 1'b1;
                    end
                end
                eas_pkg::OP_WRITE: begin
                    if (!pending_reg) begin
                        q_push       = 1'b1;
                        q_entry.cmd  = eas_pkg::CMD_WRITE;
                        q_entry.data = write_data;
                    end
                end
                eas_pkg::OP_RETURN: begin
                    if (pending_reg) begin
                        q_push       = 1'b1;
                        pending_next = 1'b0;
                        q_entry.cmd  = eas_pkg::CMD_RETURN;
                        q_entry.err  = bus_read_error;
                        q_entry.data = bus_read_error ? '0
                                     : bus_read_value[eas_pkg::BYTE_W-1:0];
                    end
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a return is only queued while a read is outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_entry.cmd == eas_pkg::CMD_RETURN) |-> pending_reg)
        else $error("return queued with no read pending");

    // a read request leaves a read outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_entry.cmd == eas_pkg::CMD_READ) |=> pending_reg)
        else $error("read request did not mark read pending");

    // nothing is queued unless a beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && q_ready))
        else $error("command queued without input beat");

endmodule

// ----- sv/eas_queue.sv -----
// Short command queue between the front and back ends.
module eas_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  eas_pkg::eas_entry_t  push_entry,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 not_empty,
    output eas_pkg::eas_entry_t  head
);

    eas_pkg::eas_entry_t slot_reg [eas_pkg::QUEUE_DEPTH];
    logic [eas_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [eas_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [eas_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign not_full  = (count_reg != eas_pkg::QCNT_W'(eas_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == eas_pkg::QPTR_W'(eas_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == eas_pkg::QPTR_W'(eas_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eas_pkg::QCNT_W'(eas_pkg::QUEUE_DEPTH))
        else $error("queue fill count overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !not_full) |-> 1'b0)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// ----- sv/eas_back.sv -----
// Back end: steps through each command and drives the result output register.
module eas_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  eas_pkg::eas_cfg_t    cfg,
    input  logic                 q_valid,
    input  eas_pkg::eas_entry_t  q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output eas_pkg::eas_beat_t   m_beat
);

    logic                        busy_reg, busy_next;
    logic [eas_pkg::STEP_W-1:0]  step_reg, step_next;
    eas_pkg::eas_entry_t         cur_reg, cur_next;
    logic                        m_valid_reg, m_valid_next;
    eas_pkg::eas_beat_t          m_beat_reg, m_beat_next;
    eas_pkg::eas_beat_t          beat;
    logic [eas_pkg::STEP_W-1:0]  last_step;
    logic [eas_pkg::BYTE_W-1:0]  mode_ctl;
    logic                        emit;
    logic                        finish;

    assign mode_ctl  = (cfg.mode_swapped ? eas_pkg::CTL_WR_B : eas_pkg::CTL_WR_A)
                     | eas_pkg::CTL_CS;
    assign last_step = (cur_reg.cmd == eas_pkg::CMD_RETURN) ? eas_pkg::STEP_LAST_RET
                                                             : eas_pkg::STEP_LAST_REQ;
    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign finish    = emit && (step_reg == last_step);
    assign q_pop     = q_valid && (!busy_reg || finish);

    // beat for the current command and step
    always_comb begin
        beat             = '0;
        beat.kind        = eas_pkg::KIND_BUS_WRITE;
        beat.bus_address = cfg.control_addr;
        beat.bus_data    = eas_pkg::CTL_REST;
        beat.last        = (step_reg == last_step);
        case (cur_reg.cmd)
            eas_pkg::CMD_READ: begin
                case (step_reg)
                    3'd1: begin
                        beat.bus_address = cur_reg.addr;
                        beat.bus_data    = '0;
                    end
                    3'd2: beat.bus_data = eas_pkg::CTL_CS;
                    3'd3: beat.bus_data = eas_pkg::CTL_CS | eas_pkg::CTL_CLK;
                    3'd4: begin
                        beat.kind        = eas_pkg::KIND_WAIT;
                        beat.bus_address = '0;
                        beat.bus_data    = '0;
                        beat.wait_us     = eas_pkg::CWAIT_W'(cfg.read_wait);
                    end
                    3'd5: beat.bus_data = eas_pkg::CTL_CS;
                    3'd6: begin
                        beat.kind        = eas_pkg::KIND_BUS_READ;
                        beat.bus_address = cfg.read_addr;
                        beat.bus_data    = '0;
                    end
                    default: beat.bus_data = eas_pkg::CTL_REST;
                endcase
            end
            eas_pkg::CMD_WRITE: begin
                case (step_reg)
                    3'd1: begin
                        beat.bus_address = cur_reg.addr;
                        beat.bus_data    = cur_reg.data;
                    end
                    3'd2: beat.bus_data = eas_pkg::CTL_WIPE | eas_pkg::CTL_CS;
                    3'd3, 3'd5: begin
                        beat.kind        = eas_pkg::KIND_WAIT;
                        beat.bus_address = '0;
                        beat.bus_data    = '0;
                        beat.wait_us     = cfg.cycle_wait;
                    end
                    3'd4: beat.bus_data = mode_ctl;
                    default: beat.bus_data = eas_pkg::CTL_REST;
                endcase
            end
            eas_pkg::CMD_RETURN: begin
                if (step_reg == '0) begin
                    beat.kind        = eas_pkg::KIND_DONE;
                    beat.bus_address = '0;
                    beat.read_value  = cur_reg.data;
                    beat.read_error  = cur_reg.err;
                end
            end
            default: beat.bus_data = eas_pkg::CTL_REST;
        endcase
    end

    // sequencer control
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        cur_next  = cur_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            step_next = '0;
            cur_next  = q_head;
        end else if (finish) begin
            busy_next = 1'b0;
        end else if (emit) begin
            step_next = step_reg + 1'b1;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_beat_next  = beat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_beat_reg <= m_beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= last_step))
        else $error("sequencer step beyond end of command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.kind == eas_pkg::KIND_DONE) |-> !m_beat_reg.last)
        else $error("completion beat marked as last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !finish) |=> (busy_reg && step_reg == $past(step_reg) + 1'b1))
        else $error("sequencer failed to advance");

endmodule

// ----- tb/tb_earom_access_sequencer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the EAROM access sequencer: random stimulus, in-line predictor.
module tb_earom_access_sequencer;

    // Opcode value that the block has no use for
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Idle cycles before a register write, covers beats still inside the block
    localparam int SETTLE_CYCLES = 16;

    // One input beat before packing
    typedef struct packed {
        logic [1:0]                   opcode;
        logic [eas_pkg::OFFSET_W-1:0] offset;
        logic [eas_pkg::BYTE_W-1:0]   wdata;
        logic [15:0]                  rd_value;
        logic                         rd_err;
    } earom_req_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // offset[5:0], write_data[13:6],
                                   // bus_read_value[29:14], bus_read_error[30]
    logic [1:0]  s_tuser   = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // bus_address[15:0], bus_data[23:16],
                                   // wait_us[43:24], read_value[51:44],
                                   // read_error[52]
    logic [1:0]  m_tuser;          // kind[1:0]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [eas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [eas_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    earom_access_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: register shadow, outstanding read, bus steps still to come
    eas_pkg::eas_cfg_t   shadow_cfg;
    logic                read_outstanding;
    eas_pkg::eas_beat_t  planned_steps[$];
    earom_req_t          req_queue[$];
    logic                gen_pending;       // outstanding read as seen by the generator
    int                  err_count = 0;

    // Driver and monitor state
    earom_req_t          tx_item;
    logic                tx_holding = 1'b0;
    int                  tx_gap     = 0;
    logic                tx_quiet   = 1'b0;
    int                  rx_stall   = 0;
    logic                rx_quiet   = 1'b0;
    eas_pkg::eas_beat_t  step;

    function automatic void push_step(eas_pkg::eas_kind_t kind,
                                      logic [eas_pkg::ADDR_W-1:0] addr,
                                      logic [eas_pkg::BYTE_W-1:0] data,
                                      logic [eas_pkg::CWAIT_W-1:0] delay_us,
                                      logic [eas_pkg::BYTE_W-1:0] rval,
                                      logic rerr, logic fin);
        eas_pkg::eas_beat_t b;
        b.kind        = kind;
        b.bus_address = addr;
        b.bus_data    = data;
        b.wait_us     = delay_us;
        b.read_value  = rval;
        b.read_error  = rerr;
        b.last        = fin;
        planned_steps.push_back(b);
    endfunction

    // Bus steps that one accepted beat gives rise to
    function automatic void plan_bus_steps(earom_req_t r);
        logic [eas_pkg::ADDR_W-1:0] latch;
        logic [eas_pkg::ADDR_W-1:0] ctl;
        logic [eas_pkg::BYTE_W-1:0] mode;
        latch = shadow_cfg.write_base
              + eas_pkg::ADDR_W'(int'(r.offset) % eas_pkg::EAROM_BYTES);
        ctl   = shadow_cfg.control_addr;
        mode  = shadow_cfg.mode_swapped ? eas_pkg::CTL_WR_B : eas_pkg::CTL_WR_A;
        if (r.opcode == eas_pkg::OP_READ && !read_outstanding) begin
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_REST, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, latch, 8'h00, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_CS, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_CS | eas_pkg::CTL_CLK,
                      '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_WAIT, '0, '0,
                      eas_pkg::CWAIT_W'(shadow_cfg.read_wait), '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_CS, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_READ, shadow_cfg.read_addr, '0, '0, '0,
                      1'b0, 1'b1);
            read_outstanding = 1'b1;
        end else if (r.opcode == eas_pkg::OP_WRITE && !read_outstanding) begin
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_REST, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, latch, r.wdata, '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_WIPE | eas_pkg::CTL_CS,
                      '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_WAIT, '0, '0, shadow_cfg.cycle_wait, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, mode | eas_pkg::CTL_CS,
                      '0, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_WAIT, '0, '0, shadow_cfg.cycle_wait, '0, 1'b0, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_REST, '0, '0, 1'b0, 1'b1);
        end else if (r.opcode == eas_pkg::OP_RETURN && read_outstanding) begin
            // failed bus read reports a zero byte
            push_step(eas_pkg::KIND_DONE, '0, '0, '0, r.rd_err ? 8'h00 : r.rd_value[7:0],
                      r.rd_err, 1'b0);
            push_step(eas_pkg::KIND_BUS_WRITE, ctl, eas_pkg::CTL_REST, '0, '0, 1'b0, 1'b1);
            read_outstanding = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Queue a beat; returns 1 if the block will act on it
    function automatic bit add_req(logic [1:0] op, logic [eas_pkg::OFFSET_W-1:0] off,
                                   logic [eas_pkg::BYTE_W-1:0] wd, logic [15:0] rv,
                                   logic re);
        earom_req_t r;
        bit acts;
        r.opcode   = op;
        r.offset   = off;
        r.wdata    = wd;
        r.rd_value = rv;
        r.rd_err   = re;
        req_queue.push_back(r);
        acts = ((op == eas_pkg::OP_READ || op == eas_pkg::OP_WRITE) && !gen_pending)
               || (op == eas_pkg::OP_RETURN && gen_pending);
        if (acts && op == eas_pkg::OP_READ)
            gen_pending = 1'b1;
        else if (acts && op == eas_pkg::OP_RETURN)
            gen_pending = 1'b0;
        return acts;
    endfunction

    function automatic bit add_random(logic [1:0] op);
        return add_req(op, eas_pkg::OFFSET_W'($urandom_range(0, 63)),
                       eas_pkg::BYTE_W'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endfunction

    // Driver: one input beat at a time, random gap before each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_holding = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                plan_bus_steps(tx_item);
                tx_holding = 1'b0;
            end
            if (!tx_holding && req_queue.size() != 0) begin
                tx_item = req_queue.pop_front();
                if ($urandom_range(0, 29) == 0)
                    tx_quiet = !tx_quiet;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 13);
                tx_holding = 1'b1;
            end
            if (tx_holding && tx_gap == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, tx_item.rd_err, tx_item.rd_value, tx_item.wdata,
                             tx_item.offset};
                s_tuser  <= tx_item.opcode;
            end else begin
                s_tvalid <= 1'b0;
                if (tx_holding)
                    tx_gap--;
            end
        end
    end

    // Monitor: compare each result beat with the oldest planned step, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (planned_steps.size() == 0) begin
                    $error("unexpected result beat: kind %0d, tdata %h", m_tuser, m_tdata);
                    err_count++;
                end else begin
                    step = planned_steps.pop_front();
                    check_field("kind", step.kind, m_tuser);
                    check_field("bus_address", step.bus_address, m_tdata[15:0]);
                    check_field("bus_data", step.bus_data, m_tdata[23:16]);
                    check_field("wait_us", step.wait_us, m_tdata[43:24]);
                    check_field("read_value", step.read_value, m_tdata[51:44]);
                    check_field("read_error", step.read_error, m_tdata[52]);
                    check_field("last", step.last, m_tlast);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 13);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [eas_pkg::CFG_IDX_W-1:0] idx,
                             logic [eas_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            eas_pkg::REG_WRITE_BASE: shadow_cfg.write_base   = val[eas_pkg::ADDR_W-1:0];
            eas_pkg::REG_CONTROL:    shadow_cfg.control_addr = val[eas_pkg::ADDR_W-1:0];
            eas_pkg::REG_READ_ADDR:  shadow_cfg.read_addr    = val[eas_pkg::ADDR_W-1:0];
            eas_pkg::REG_MODE_SWAP:  shadow_cfg.mode_swapped = val[0];
            eas_pkg::REG_READ_WAIT:  shadow_cfg.read_wait    = val[eas_pkg::RWAIT_W-1:0];
            eas_pkg::REG_CYCLE_WAIT: shadow_cfg.cycle_wait   = val[eas_pkg::CWAIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [15:0] base, logic [15:0] ctl, logic [15:0] rd,
                                logic swap, logic [eas_pkg::RWAIT_W-1:0] rwait,
                                logic [eas_pkg::CWAIT_W-1:0] cwait);
        write_reg(eas_pkg::REG_WRITE_BASE, eas_pkg::CFG_DATA_W'(base));
        write_reg(eas_pkg::REG_CONTROL, eas_pkg::CFG_DATA_W'(ctl));
        write_reg(eas_pkg::REG_READ_ADDR, eas_pkg::CFG_DATA_W'(rd));
        write_reg(eas_pkg::REG_MODE_SWAP, eas_pkg::CFG_DATA_W'(swap));
        write_reg(eas_pkg::REG_READ_WAIT, eas_pkg::CFG_DATA_W'(rwait));
        write_reg(eas_pkg::REG_CYCLE_WAIT, cwait);
    endtask

    // Hold off until every planned step has been seen and the block has gone quiet
    task automatic settle();
        do @(posedge aclk);
        while (req_queue.size() != 0 || tx_holding || planned_steps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Field extremes, every opcode and each ignored case
    task automatic queue_directed();
        void'(add_req(eas_pkg::OP_READ, 6'd0, 8'h00, 16'h0000, 1'b0));
        void'(add_req(eas_pkg::OP_RETURN, 6'd0, 8'h00, 16'hFFFF, 1'b0));
        void'(add_req(eas_pkg::OP_READ, 6'd63, 8'hFF, 16'hFFFF, 1'b1));
        // requests and a spare opcode while the read is outstanding
        void'(add_req(eas_pkg::OP_WRITE, 6'd5, 8'h5A, 16'h0000, 1'b0));
        void'(add_req(eas_pkg::OP_READ, 6'd9, 8'h00, 16'h0000, 1'b0));
        void'(add_req(OP_SPARE, 6'd63, 8'hFF, 16'hFFFF, 1'b1));
        // bus error on the return: byte forced to zero
        void'(add_req(eas_pkg::OP_RETURN, 6'd0, 8'h00, 16'hABCD, 1'b1));
        // return with nothing outstanding
        void'(add_req(eas_pkg::OP_RETURN, 6'd0, 8'h00, 16'h1234, 1'b0));
        void'(add_req(eas_pkg::OP_WRITE, 6'd0, 8'h00, 16'h0000, 1'b0));
        void'(add_req(eas_pkg::OP_WRITE, 6'd63, 8'hFF, 16'hFFFF, 1'b1));
        void'(add_req(OP_SPARE, 6'd0, 8'h00, 16'h0000, 1'b0));
        void'(add_req(eas_pkg::OP_READ, 6'd42, 8'hA5, 16'h0000, 1'b0));
        void'(add_req(eas_pkg::OP_RETURN, 6'd63, 8'hFF, 16'h55AA, 1'b0));
        void'(add_req(eas_pkg::OP_WRITE, 6'd21, 8'h96, 16'h0F0F, 1'b0));
    endtask

    // Mostly well-formed traffic (read then return, writes) with some noise
    task automatic queue_traffic(int n);
        int acted;
        int pick;
        acted = 0;
        while (acted < n) begin
            pick = $urandom_range(0, 99);
            if (gen_pending) begin
                if (pick < 80)
                    acted += add_random(eas_pkg::OP_RETURN);
                else
                    acted += add_random(2'($urandom_range(0, 3)));
            end else if (pick < 45) begin
                acted += add_random(eas_pkg::OP_READ);
            end else if (pick < 85) begin
                acted += add_random(eas_pkg::OP_WRITE);
            end else begin
                acted += add_random(2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        shadow_cfg.write_base   = '0;
        shadow_cfg.control_addr = '0;
        shadow_cfg.read_addr    = '0;
        shadow_cfg.mode_swapped = 1'b0;
        shadow_cfg.read_wait    = eas_pkg::READ_WAIT_RST;
        shadow_cfg.cycle_wait   = eas_pkg::CYCLE_WAIT_RST;
        read_outstanding = 1'b0;
        gen_pending      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults
        queue_directed();
        settle();

        // addresses at their top value and mode swapped, base wraps with the offset
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 10'd1000, 20'd1000000);
        queue_directed();
        queue_traffic(80);
        settle();

        // everything zero
        program_regs(16'h0000, 16'h0000, 16'h0000, 1'b0, 10'd0, 20'd0);
        queue_traffic(60);
        settle();

        // random settings
        repeat (3) begin
            program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         10'($urandom_range(0, 1000)), 20'($urandom_range(0, 1000000)));
            queue_traffic(50);
            settle();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
